@@ rtl/core/sidch_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidch_pkg: shared types and constants of the download-code hash
// Holds the field widths and the command and status groups that link the
// controller to the datapath.
// ----------------------------------------------------------------------------
package sidch_pkg;

   localparam int unsigned ID_W    = 32;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned TDATA_W = 40;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // latch the accepted item
      logic take_byte;  // fold the latched byte into both hashes
      logic sum;        // first term of the code
      logic mul1;       // first multiplication
      logic mul2;       // second multiplication, result out, hashes cleared
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic no_byte;    // latched item carries no byte
      logic last;       // latched item ends the string
      logic out_full;   // result register cannot take a new code this cycle
   } status_type;

endpackage

@@ rtl/core/string_id_download_code_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_id_download_code_hash: download code from a byte string and an id
// Hashes string bytes forward and backward and combines them with the
// permuted entry id into one 32-bit code per string.
// ----------------------------------------------------------------------------
// One item is taken at a time. A byte item passes through the accept state
// and one update state in which the shared 32x32 multiplier forms the byte's
// weighted term. An item marked last then adds the sum and two products
// through the same multiplier before the code sits in the output register;
// the next item is accepted right after, even while that code still waits
// to be taken. A last item whose code finds the output register still full
// waits in the second product until it drains.
module string_id_download_code_hash (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic                             csr_wdata,   // sign_extend_bytes
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sidch_pkg::TDATA_W-1:0]    req_tdata,   // entry_id[31:0], text_byte[39:32]
   input  logic                             req_tuser,   // no_byte
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sidch_pkg::WORD_W-1:0]     rsp_tdata    // download_code[31:0]
);

   sidch_pkg::cmd_type    cmd;
   sidch_pkg::status_type status;

   sidch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sidch_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/core/sidch_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidch_datapath: hash registers, shared multiplier and result register
// Keeps the forward and reverse hashes and forms the code through one
// 32x32 multiplier shared between the byte step and the two final products.
// ----------------------------------------------------------------------------
module sidch_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic                                  csr_wdata,
   input  logic [sidch_pkg::TDATA_W-1:0]         req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  req_tlast,
   input  sidch_pkg::cmd_type                    cmd,
   output sidch_pkg::status_type                 status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sidch_pkg::WORD_W-1:0]          rsp_tdata
);

   logic                              sext_ff;
   logic [sidch_pkg::ID_W-1:0]        id_ff;
   logic [sidch_pkg::BYTE_W-1:0]      byte_ff;
   logic                              no_byte_ff;
   logic                              last_ff;
   logic [sidch_pkg::WORD_W-1:0]      rsum_ff,   rsum_in;
   logic [sidch_pkg::WORD_W-1:0]      weight_ff, weight_in;
   logic [sidch_pkg::WORD_W-1:0]      fsum_ff,   fsum_in;
   logic                              odd_ff,    odd_in;
   logic [sidch_pkg::WORD_W-1:0]      prod_ff,   prod_in;
   logic [sidch_pkg::WORD_W-1:0]      code_ff;
   logic                              valid_ff,  valid_in;

   logic [sidch_pkg::WORD_W-1:0]      byte_ext;
   logic [sidch_pkg::WORD_W-1:0]      perm;
   logic [sidch_pkg::WORD_W-1:0]      mul_a, mul_b, mul_p;
   logic [7:0]                        id_a, id_b, id_c, id_d;

   // Permuted identifier; an empty upper byte takes the complement of a lower one.
   always_comb begin
      id_a = id_ff[7:0];
      id_b = id_ff[15:8];
      id_c = (id_ff[23:16] == 8'h00) ? ~id_ff[15:8] : id_ff[23:16];
      id_d = (id_ff[31:24] == 8'h00) ? ~id_ff[7:0]  : id_ff[31:24];
      perm = {id_a, id_c, id_b, id_d};
   end

   assign byte_ext = sext_ff ? {{(sidch_pkg::WORD_W-sidch_pkg::BYTE_W){byte_ff[7]}}, byte_ff}
                             : {{(sidch_pkg::WORD_W-sidch_pkg::BYTE_W){1'b0}}, byte_ff};

   always_comb begin
      if (cmd.mul1) begin
         mul_a = prod_ff;
         mul_b = fsum_ff | perm;
      end else if (cmd.mul2) begin
         mul_a = prod_ff;
         mul_b = rsum_ff ^ id_ff;
      end else begin
         mul_a = byte_ext;
         mul_b = weight_ff;
      end
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      rsum_in   = rsum_ff;
      weight_in = weight_ff;
      fsum_in   = fsum_ff;
      odd_in    = odd_ff;
      prod_in   = prod_ff;
      valid_in  = valid_ff & ~rsp_tready;
      if (cmd.take_byte) begin
         rsum_in = rsum_ff + mul_p;
         if (odd_ff) begin
            weight_in = (weight_ff << 5) + weight_ff;
            fsum_in   = (fsum_ff << 4) + fsum_ff + byte_ext;
         end else begin
            weight_in = (weight_ff << 4) + weight_ff;
            fsum_in   = (fsum_ff << 3) + fsum_ff + byte_ext;
         end
         odd_in = ~odd_ff;
      end
      if (cmd.sum) begin
         prod_in = (rsum_ff ^ perm) + (fsum_ff | id_ff);
      end
      if (cmd.mul1) begin
         prod_in = mul_p;
      end
      if (cmd.mul2) begin
         valid_in  = 1'b1;
         rsum_in   = '0;
         weight_in = {{(sidch_pkg::WORD_W-1){1'b0}}, 1'b1};
         fsum_in   = '0;
         odd_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sext_ff   <= 1'b1;
         rsum_ff   <= '0;
         weight_ff <= {{(sidch_pkg::WORD_W-1){1'b0}}, 1'b1};
         fsum_ff   <= '0;
         odd_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_wen) begin
            sext_ff <= csr_wdata;
         end
         rsum_ff   <= rsum_in;
         weight_ff <= weight_in;
         fsum_ff   <= fsum_in;
         odd_ff    <= odd_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff      <= req_tdata[sidch_pkg::ID_W-1:0];
         byte_ff    <= req_tdata[sidch_pkg::TDATA_W-1:sidch_pkg::ID_W];
         no_byte_ff <= req_tuser;
         last_ff    <= req_tlast;
      end
      prod_ff <= prod_in;
      if (cmd.mul2) begin
         code_ff <= mul_p;
      end
   end

   assign status.no_byte  = no_byte_ff;
   assign status.last     = last_ff;
   assign status.out_full = valid_ff & ~rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = code_ff;

endmodule

@@ rtl/core/sidch_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidch_ctrl: sequencer of the download-code hash
// Accepts one item at a time, steps the byte update and, on the last item,
// the sum and the two multiplications that form the code.
// ----------------------------------------------------------------------------
module sidch_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  sidch_pkg::status_type status,
   output sidch_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_BYTE = 5'b00010,
      S_SUM  = 5'b00100,
      S_MUL1 = 5'b01000,
      S_MUL2 = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.load      = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_BYTE;
            end
         end
         S_BYTE: begin
            cmd.take_byte = ~status.no_byte;
            state_in      = status.last ? S_SUM : S_IDLE;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            // Hold the last product until the result register frees up.
            if (!status.out_full) begin
               cmd.mul2 = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_byte: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_BYTE)
      else $error("accepted item not followed by byte step");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !accept)
      else $error("item accepted while busy");

   a_mul2_room: assert property (@(posedge clock) disable iff (reset)
      cmd.mul2 |-> !status.out_full)
      else $error("code written over a waiting result");

   a_sum_then_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.sum |=> cmd.mul1)
      else $error("first multiplication does not follow the sum");
`endif

endmodule
